[rtl/fmp_pkg.sv]
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types and fixed field widths for the Fibonacci-mod-m block.
// ----------------------------------------------------------------------------
`default_nettype none

package fmp_pkg;

   localparam int INDEX_W   = 63;  // request index field
   localparam int MODULUS_W = 18;  // request modulus field
   localparam int FIB_W     = 17;  // response field

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEARCH,
      PH_REDUCE,
      PH_WALK
   } phase_type;

endpackage

`default_nettype wire

[rtl/fmp_addmod.sv]
// ----------------------------------------------------------------------------
// fmp_addmod
// Shared modular adder: a + b, then one conditional subtract of m.
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_addmod #(
   parameter int W = 18
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] m,
   output logic      [W-1:0] sum
);

   logic [W:0] raw;

   always_comb begin
      raw = {1'b0, a} + {1'b0, b};
      if (raw >= {1'b0, m}) begin
         raw = raw - {1'b0, m};
      end
      sum = raw[W-1:0];
   end

endmodule

`default_nettype wire

[rtl/fmp_rem.sv]
// ----------------------------------------------------------------------------
// fmp_rem
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_rem #(
   parameter int NW = 63,
   parameter int DW = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] remainder
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] shift_ff, shift_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[NW-1]};
      done     = busy_ff && (cnt_ff == '0);
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CW'(NW);
         shift_in = dividend;
         rem_in   = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         // shift in the next bit, subtract if it fits
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in   = trial[DW-1:0];
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - CW'(1);
      end
   end

   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/fibonacci_mod_pisano.sv]
// ----------------------------------------------------------------------------
// fibonacci_mod_pisano
// F(n) mod m: Pisano period search, serial reduction of n, then a short walk.
// ----------------------------------------------------------------------------
// sequence: period search (p up to 6m), serial reduction n mod p over INDEX_BITS
//   bits, then a walk of (n mod p) steps; m of one or zero skips to the walk
// throughput: one request at a time, req_ready only while idle; the single shared
//   modular adder serves both the period search and the walk
// reset: synchronous, clears the sequencer, remainder unit and rsp_valid
`default_nettype none

module fibonacci_mod_pisano #(
   parameter int MODULUS_MAX = 131072,
   parameter int INDEX_BITS  = 63
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [fmp_pkg::INDEX_W-1:0]   req_fib_index,
   input  wire logic [fmp_pkg::MODULUS_W-1:0] req_modulus,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [fmp_pkg::FIB_W-1:0]     rsp_fib_mod
);

   import fmp_pkg::*;

   // largest modulus the request field can carry after saturation
   localparam int MOD_CAP = (MODULUS_MAX < (2 ** MODULUS_W)) ?
                            MODULUS_MAX : (2 ** MODULUS_W) - 1;
   localparam int MW      = $clog2(MOD_CAP + 1);      // sequence values
   localparam int PW      = $clog2(6 * MOD_CAP + 1);  // period and step counts

   phase_type             phase_ff, phase_in;
   logic [MW-1:0]         mod_ff, mod_in;
   logic [MW-1:0]         seq_prev_ff, seq_prev_in;
   logic [MW-1:0]         seq_curr_ff, seq_curr_in;
   logic [PW-1:0]         step_count_ff, step_count_in;
   logic [PW-1:0]         bound_ff, bound_in;
   logic [PW-1:0]         period_len_ff, period_len_in;
   logic [PW-1:0]         reduced_index_ff, reduced_index_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIB_W-1:0]      rsp_fib_mod_ff, rsp_fib_mod_in;

   logic [MW-1:0]         mod_sat;
   logic [MW-1:0]         step_sum;
   logic                  rem_start;
   logic                  rem_done;
   logic [PW-1:0]         rem_value;
   logic                  out_free;

   // one modular adder serves both the period search and the walk
   fmp_addmod #(
      .W (MW)
   ) u_addmod (
      .a   (seq_prev_ff),
      .b   (seq_curr_ff),
      .m   (mod_ff),
      .sum (step_sum)
   );

   // n mod period, one index bit per cycle
   fmp_rem #(
      .NW (INDEX_BITS),
      .DW (PW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (index_ff),
      .divisor   (period_len_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // modulus above the cap saturates to the cap
   always_comb begin
      if (32'(req_modulus) > 32'(MOD_CAP)) begin
         mod_sat = MW'(MOD_CAP);
      end else begin
         mod_sat = MW'(req_modulus);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mod_ff           <= mod_in;
      seq_prev_ff      <= seq_prev_in;
      seq_curr_ff      <= seq_curr_in;
      step_count_ff    <= step_count_in;
      bound_ff         <= bound_in;
      period_len_ff    <= period_len_in;
      reduced_index_ff <= reduced_index_in;
      index_ff         <= index_in;
      rsp_fib_mod_ff   <= rsp_fib_mod_in;
   end

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      phase_in         = phase_ff;
      mod_in           = mod_ff;
      seq_prev_in      = seq_prev_ff;
      seq_curr_in      = seq_curr_ff;
      step_count_in    = step_count_ff;
      bound_in         = bound_ff;
      period_len_in    = period_len_ff;
      reduced_index_in = reduced_index_ff;
      index_in         = index_ff;
      rsp_fib_mod_in   = rsp_fib_mod_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rem_start        = 1'b0;
      req_ready        = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mod_in      = mod_sat;
               index_in    = req_fib_index[INDEX_BITS-1:0];
               bound_in    = (PW'(mod_sat) << 2) + (PW'(mod_sat) << 1);
               seq_prev_in = '0;
               seq_curr_in = MW'(1);
               if (mod_sat <= MW'(1)) begin
                  // modulus one or zero: answer is zero, no search
                  period_len_in    = PW'(1);
                  reduced_index_in = '0;
                  step_count_in    = '0;
                  phase_in         = PH_WALK;
               end else begin
                  step_count_in = PW'(1);
                  phase_in      = PH_SEARCH;
               end
            end
         end

         PH_SEARCH: begin
            // step k: pair moves to (curr, sum); stop when it is (0,1) again
            if ((seq_curr_ff == '0 && step_sum == MW'(1)) ||
                (step_count_ff == bound_ff)) begin
               period_len_in = step_count_ff;
               rem_start     = 1'b1;
               phase_in      = PH_REDUCE;
            end else begin
               seq_prev_in   = seq_curr_ff;
               seq_curr_in   = step_sum;
               step_count_in = step_count_ff + PW'(1);
            end
         end

         PH_REDUCE: begin
            if (rem_done) begin
               reduced_index_in = rem_value;
               seq_prev_in      = '0;
               seq_curr_in      = MW'(1);
               step_count_in    = '0;
               phase_in         = PH_WALK;
            end
         end

         PH_WALK: begin
            if (step_count_ff == reduced_index_ff) begin
               // pair is (F(k), F(k+1)); hand out F(k) once the slot frees
               if (out_free) begin
                  rsp_fib_mod_in = FIB_W'(seq_prev_ff);
                  rsp_valid_in   = 1'b1;
                  phase_in       = PH_IDLE;
               end
            end else begin
               seq_prev_in   = seq_curr_ff;
               seq_curr_in   = step_sum;
               step_count_in = step_count_ff + PW'(1);
            end
         end

         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_fib_mod = rsp_fib_mod_ff;

endmodule

`default_nettype wire
